// ===== rtl/bfts_pkg.sv =====
package bfts_pkg;

  localparam int DepthDefault = 1024;
  localparam int TimeW        = 32;
  localparam int FinishW      = 48;
  localparam int LimitW       = 11;
  localparam int RegIdxW      = 1;
  localparam int ApbAddrW     = 3;
  localparam int ApbDataW     = 32;

  localparam logic [LimitW-1:0]   QueueLimitReset = LimitW'(1024);
  localparam logic [RegIdxW-1:0]  RegQueueLimit   = RegIdxW'(0);

endpackage

// ===== rtl/bounded_fifo_task_server_unit.sv =====
// channel   | signals                                        | accepted when
// ----------+------------------------------------------------+-------------------------------
// request   | in_valid_i, in_ready_o, arrival_time_i,        | in_valid_i && in_ready_o
//           | duration_i                                     |
// result    | out_valid_o, out_ready_i, accepted_o,          | out_valid_o && out_ready_i
//           | finish_time_o                                  |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,  | psel && penable && pwrite
//           | pready                                         |
//
// an item is taken in StIdle, then stays in StCheck until the finish times at or before its arrival are retired;
// each retire is one read of the ring memory, which has one write and one read port (one read a cycle)
// a request is taken while the previous result still sits in the output register
// the result is held back only while that register is occupied and not taken
// reset is asynchronous, active low, and needs no clearing pass over the ring
module bounded_fifo_task_server_unit
  import bfts_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TimeW-1:0]    arrival_time_i,
  input  logic [TimeW-1:0]    duration_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [FinishW-1:0]  finish_time_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LimitW) ? CW : LimitW;

  typedef enum logic {StIdle, StCheck} state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [FinishW-1:0]  last_q, last_d;
  logic [TimeW-1:0]    arr_q, arr_d, dur_q, dur_d;
  logic                out_valid_q, out_valid_d;
  logic                acc_q, acc_d;
  logic [FinishW-1:0]  fin_q, fin_d;
  logic [LimitW-1:0]   limit_q;

  logic [FinishW-1:0]  ring [DEPTH];
  logic [FinishW-1:0]  rd_data_q;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;

  logic [AW-1:0]       head_inc, tail_inc;
  logic [LW-1:0]       lim_eff;
  logic                pop, decide, room, out_free;
  logic [FinishW-1:0]  base, fin_val;
  logic [FinishW:0]    sum;
  logic                cfg_wr;
  logic [RegIdxW-1:0]  reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegQueueLimit: prdata = ApbDataW'(limit_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= QueueLimitReset;
    end else if (cfg_wr && reg_idx == RegQueueLimit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // datapath
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
  assign lim_eff  = (LW'(limit_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit_q);
  assign room     = LW'(count_q) < lim_eff;
  assign out_free = !out_valid_q || out_ready_i;

  // retire the front while its finish time is at or before the arrival
  assign pop    = (state_q == StCheck) && (count_q != '0) &&
                  (rd_data_q <= FinishW'(arr_q));
  assign decide = (state_q == StCheck) && !pop && out_free;
  assign wr_en  = decide && room;

  assign base    = (count_q == '0) ? FinishW'(arr_q) : last_q;
  assign sum     = {1'b0, base} + (FinishW + 1)'(dur_q);
  assign fin_val = sum[FinishW] ? '1 : sum[FinishW-1:0];

  // a pop prefetches the next front so the compare runs every cycle
  assign rd_addr = pop ? head_inc : head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring[tail_q] <= fin_val;
    end
    rd_data_q <= ring[rd_addr];
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    last_d      = last_q;
    arr_d       = arr_q;
    dur_d       = dur_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    fin_d       = fin_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          arr_d   = arrival_time_i;
          dur_d   = duration_i;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (pop) begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end else if (decide) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (room) begin
            acc_d   = 1'b1;
            fin_d   = fin_val;
            tail_d  = tail_inc;
            count_d = count_q + CW'(1);
            last_d  = fin_val;
          end else begin
            acc_d = 1'b0;
            fin_d = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      last_q      <= '0;
      arr_q       <= '0;
      dur_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      fin_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      last_q      <= last_d;
      arr_q       <= arr_d;
      dur_q       <= dur_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      fin_q       <= fin_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign finish_time_o = fin_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(DEPTH))
    else $error("held count above ring depth");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0)
    else $error("retire from empty ring");

  a_drop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> finish_time_o == '0)
    else $error("dropped item carries a finish time");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

// ===== bench/tb_bounded_fifo_task_server_unit.sv =====
`timescale 1ns / 1ps

module tb_bounded_fifo_task_server_unit;
  import bfts_pkg::*;

  typedef struct {
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] duration;
    int               gap;
    bit               drain;
  } task_req_t;

  typedef struct {
    logic               accepted;
    logic [FinishW-1:0] finish;
  } verdict_t;

  localparam logic [FinishW-1:0]  FinishMax  = '1;
  localparam logic [TimeW-1:0]    TimeMax    = '1;
  localparam logic [ApbAddrW-1:0] LimitAddr  = ApbAddrW'({RegQueueLimit, 2'b00});
  localparam int                  HoldCycles = 400;
  localparam int                  PhaseItems = 65;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [TimeW-1:0]    arrival_time_i = '0;
  logic [TimeW-1:0]    duration_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                accepted_o;
  logic [FinishW-1:0]  finish_time_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ApbAddrW-1:0] paddr          = '0;
  logic [ApbDataW-1:0] pwdata         = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  task_req_t          request_q[$];
  verdict_t           verdict_q[$];
  logic [FinishW-1:0] held_finish_q[$];
  logic [FinishW-1:0] last_finish  = '0;
  logic [LimitW-1:0]  limit_shadow = QueueLimitReset;
  int                 fail_cnt     = 0;

  task_req_t next_req;
  bit        have_next  = 1'b0;
  int        send_wait  = 0;
  bit        send_quiet = 1'b0;
  int        recv_wait  = 0;
  bit        recv_quiet = 1'b0;
  bit        hold_req   = 1'b0;
  bit        hold_seen  = 1'b0;

  bounded_fifo_task_server_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .arrival_time_i(arrival_time_i),
    .duration_i    (duration_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .finish_time_o (finish_time_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // idle cycles before an item, with runs of back-to-back traffic
  function automatic int draw_idle(ref bit quiet_run);
    if ($urandom_range(0, 19) == 0) quiet_run = !quiet_run;
    return quiet_run ? 0 : $urandom_range(0, 17);
  endfunction

  // retire finished tasks, then queue or drop the new one
  function automatic void schedule_task(logic [TimeW-1:0] arrival,
                                        logic [TimeW-1:0] duration);
    int          cap;
    logic [FinishW:0] sum;
    verdict_t    v;
    cap = (limit_shadow > DepthDefault) ? DepthDefault : int'(limit_shadow);
    while (held_finish_q.size() > 0 && held_finish_q[0] <= FinishW'(arrival))
      void'(held_finish_q.pop_front());
    if (held_finish_q.size() < cap) begin
      sum = (held_finish_q.size() == 0) ? (FinishW+1)'(arrival) : {1'b0, last_finish};
      sum = sum + duration;
      v.accepted = 1'b1;
      v.finish   = sum[FinishW] ? FinishMax : sum[FinishW-1:0];
      held_finish_q.push_back(v.finish);
      last_finish = v.finish;
    end else begin
      v.accepted = 1'b0;
      v.finish   = '0;
    end
    verdict_q.push_back(v);
  endfunction

  function automatic void add_request(logic [TimeW-1:0] arrival,
                                      logic [TimeW-1:0] duration, bit drain);
    task_req_t r;
    r.arrival  = arrival;
    r.duration = duration;
    r.gap      = draw_idle(send_quiet);
    r.drain    = drain;
    request_q.push_back(r);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      arrival_time_i <= '0;
      duration_i     <= '0;
      have_next = 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) schedule_task(arrival_time_i, duration_i);
      if (!in_valid_i || in_ready_o) begin
        // a draining item waits until every result is back
        if (!have_next && request_q.size() > 0 &&
            !(request_q[0].drain && verdict_q.size() > 0)) begin
          next_req  = request_q.pop_front();
          send_wait = next_req.gap;
          have_next = 1'b1;
        end
        if (have_next && send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (have_next) begin
          in_valid_i     <= 1'b1;
          arrival_time_i <= next_req.arrival;
          duration_i     <= next_req.duration;
          have_next = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual accepted %0b finish %0d",
                   $time, accepted_o, finish_time_o);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (accepted_o !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %0b, actual %0b",
                     $time, want.accepted, accepted_o);
            fail_cnt++;
          end
          if (finish_time_o !== want.finish) begin
            $display("%0t: finish_time mismatch, expected %0d, actual %0d",
                     $time, want.finish, finish_time_o);
            fail_cnt++;
          end
        end
        recv_wait = draw_idle(recv_quiet);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_req && !hold_seen) begin
        recv_wait = HoldCycles;
        hold_seen = 1'b1;
      end
      out_ready_i <= (recv_wait == 0);
    end
  end

  task automatic check_limit_reg(logic [LimitW-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LimitAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== ApbDataW'(want)) begin
      $display("%0t: queue_limit readback mismatch, expected %0d, actual %0d",
               $time, want, prdata);
      fail_cnt++;
    end
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_limit(logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_shadow = value[LimitW-1:0];
    check_limit_reg(value[LimitW-1:0]);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() > 0 || have_next || in_valid_i || verdict_q.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  // with the limit at zero nothing is queued, and an arrival at the top of
  // the time range retires every held task
  task automatic clear_queue();
    wait_idle();
    write_limit('0);
    add_request($urandom(), $urandom(), 1'b0);
    add_request(TimeMax, $urandom(), 1'b0);
    wait_idle();
  endtask

  // load kept low enough that no finish time passes the top arrival
  task automatic run_phase(logic [LimitW-1:0] lim, int n);
    int                cap;
    longint unsigned   s_cap;
    longint unsigned   s;
    longint unsigned   span;
    logic [TimeW-1:0]  base;
    logic [TimeW-1:0]  arr;
    logic [TimeW-1:0]  dur_cap;
    cap = (lim > DepthDefault) ? DepthDefault : int'(lim);
    write_limit(ApbDataW'(lim));
    s_cap = 64'd2147483648 / (2 * n + 8 * cap);
    if ($urandom_range(0, 2) == 0) s = $urandom_range(1, 4);
    else s = $urandom_range(1, 32'(s_cap));
    dur_cap = 32'(s * $urandom_range(1, 8));
    span    = 2 * n * s + 8 * cap * s;
    base    = $urandom_range(0, 32'(64'hFFFF_FFFF - span));
    arr     = base;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) arr = base + $urandom_range(0, arr - base);
      else arr = arr + $urandom_range(0, 32'(2 * s));
      add_request(arr, ($urandom_range(0, 9) == 0) ? '0 : $urandom_range(0, dur_cap),
                  (i == n / 2) || ($urandom_range(0, 39) == 0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_limit_reg(QueueLimitReset);

    // reset limit: retiring at equal times, chaining, arrival going backwards
    add_request(32'd0, 32'd0, 1'b0);
    add_request(32'd0, 32'd0, 1'b0);
    add_request(32'd10, 32'd5, 1'b0);
    add_request(32'd12, 32'd7, 1'b0);
    add_request(32'd11, 32'd1, 1'b0);
    add_request(32'd15, 32'd2, 1'b0);
    add_request(32'd30, 32'd0, 1'b0);
    add_request(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_request(32'h8000_0000, 32'd0, 1'b0);
    add_request(TimeMax, 32'd0, 1'b0);
    wait_idle();

    // limit of zero drops everything
    write_limit('0);
    add_request(32'd0, TimeMax, 1'b0);
    add_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_request(TimeMax, TimeMax, 1'b0);
    wait_idle();

    // limit of one, written with junk above the field
    write_limit(32'hFFFF_F801);
    add_request(32'd0, TimeMax, 1'b0);
    add_request(32'd7, 32'd1, 1'b0);
    add_request(TimeMax, 32'd0, 1'b0);
    add_request(TimeMax, 32'd0, 1'b0);
    clear_queue();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: run_phase(11'd1, PhaseItems);
        1: run_phase(11'd2, PhaseItems);
        2: run_phase(LimitW'($urandom_range(3, 16)), PhaseItems);
        3: run_phase(11'd1024, PhaseItems);
        4: run_phase(LimitW'($urandom_range(17, 1023)), PhaseItems);
        default: run_phase(LimitW'($urandom_range(1025, 2047)), PhaseItems);
      endcase
      // long receiver stall while requests keep coming
      if (p == 0) @(negedge clk_i) hold_req = 1'b1;
      clear_queue();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
